// ===== sv/esms_pkg.sv =====
// ----------------------------------------------------------------------------
// esms_pkg
// Shared widths, codes and types for the event slot minimum select block.
// ----------------------------------------------------------------------------
package esms_pkg;

  localparam int MAX_DEVICES = 16;
  localparam int NUM_FUNCS   = 16;

  localparam int DEV_W   = $clog2(MAX_DEVICES);
  localparam int ACT_W   = DEV_W + 1;
  localparam int TIME_W  = 64;
  localparam int PRIO_W  = 4;
  localparam int REQ_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

  localparam logic [TIME_W-1:0] SLOT_IDLE_TIME = {TIME_W{1'b1}};
  localparam logic [PRIO_W-1:0] PRIO_NONE      = '0;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(MAX_DEVICES);

  typedef struct packed {
    logic             valid;
    logic             first;
    logic [DEV_W-1:0] idx;
  } cmp_ctl_t;

endpackage

// ===== sv/esms_req_if.sv =====
// ----------------------------------------------------------------------------
// esms_req_if
// Request channel: add, remove and find requests with valid/ready transfer.
// ----------------------------------------------------------------------------
interface esms_req_if
  import esms_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DEV_W-1:0]  device;
  logic [TIME_W-1:0] event_time;
  logic [PRIO_W-1:0] func_priority;

  modport source (output valid, req_type, device, event_time, func_priority, input ready);
  modport sink   (input valid, req_type, device, event_time, func_priority, output ready);
endinterface

// ===== sv/esms_rsp_if.sv =====
// ----------------------------------------------------------------------------
// esms_rsp_if
// Response channel: selected slot with its time and priority.
// ----------------------------------------------------------------------------
interface esms_rsp_if
  import esms_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DEV_W-1:0]  next_device;
  logic [TIME_W-1:0] next_time;
  logic [PRIO_W-1:0] next_func;

  modport source (output valid, next_device, next_time, next_func, input ready);
  modport sink   (input valid, next_device, next_time, next_func, output ready);
endinterface

// ===== sv/esms_slot_ram.sv =====
// ----------------------------------------------------------------------------
// esms_slot_ram
// Slot store: one write port, one registered read port, per-entry valid bits
// so that unwritten slots read as never / none.
// ----------------------------------------------------------------------------
module esms_slot_ram
  import esms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [DEV_W-1:0]  waddr,
  input  logic [TIME_W-1:0] wtime,
  input  logic [PRIO_W-1:0] wprio,
  input  logic [DEV_W-1:0]  raddr,
  output logic [TIME_W-1:0] rd_time,
  output logic [PRIO_W-1:0] rd_prio
);

  logic [TIME_W-1:0]      mem_time [MAX_DEVICES];
  logic [PRIO_W-1:0]      mem_prio [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_time[waddr] <= wtime;
      mem_prio[waddr] <= wprio;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[raddr]) begin
      rd_time <= mem_time[raddr];
      rd_prio <= mem_prio[raddr];
    end else begin
      rd_time <= SLOT_IDLE_TIME;
      rd_prio <= PRIO_NONE;
    end
  end

endmodule

// ===== sv/esms_min_unit.sv =====
// ----------------------------------------------------------------------------
// esms_min_unit
// Shared compare unit: folds one slot per cycle into the running best,
// lowest time first, then higher priority, then lower index.
// ----------------------------------------------------------------------------
module esms_min_unit
  import esms_pkg::*;
(
  input  logic              clk,
  input  cmp_ctl_t          cmp,
  input  logic [TIME_W-1:0] rd_time,
  input  logic [PRIO_W-1:0] rd_prio,
  output logic [DEV_W-1:0]  best_idx
);

  logic [TIME_W-1:0] best_time;
  logic [PRIO_W-1:0] best_prio;
  logic              take;

  always_comb begin
    take = cmp.first || (rd_time < best_time) ||
           ((rd_time == best_time) && (rd_prio > best_prio));
  end

  always_ff @(posedge clk) begin
    if (cmp.valid && take) begin
      best_time <= rd_time;
      best_prio <= rd_prio;
      best_idx  <= cmp.idx;
    end
  end

endmodule

// ===== sv/event_slot_min_select_core.sv =====
// ----------------------------------------------------------------------------
// event_slot_min_select_core
// Pending event slot store with add, remove and find-earliest requests.
//
//   channel  dir  transfer               payload
//   req      in   valid && ready         req_type, device, event_time, func_priority
//   rsp      out  valid && ready         next_device, next_time, next_func
//   apb      in   psel&penable&pwrite    active_devices at paddr 0 to 3
//
// add and remove of an active slot: WRITE, READ and LOAD states, then the response
// ignored device and unused code: READ and LOAD states only, no slot write
// find: scans n slots, n the active count, one slot a cycle through the shared unit
// one request at a time; the next is taken while the response still waits
// a stalled response holds the last step until the output register frees
// rst is synchronous; slots read as never / none until written
// ----------------------------------------------------------------------------
module event_slot_min_select_core
  import esms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  esms_req_if.sink           req,
  esms_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_SCAN, S_DRAIN, S_COMMIT, S_READ, S_LOAD
  } state_t;

  state_t            state;
  logic [ACT_W-1:0]  active_devices;
  logic [ACT_W-1:0]  eff_n;
  logic [DEV_W-1:0]  chosen;
  logic [DEV_W-1:0]  scan_cnt;
  logic [DEV_W-1:0]  wr_dev;
  logic [TIME_W-1:0] wr_time;
  logic [PRIO_W-1:0] wr_prio;
  cmp_ctl_t          cmp;
  logic              ram_we;
  logic [DEV_W-1:0]  ram_raddr;
  logic [TIME_W-1:0] rd_time;
  logic [PRIO_W-1:0] rd_prio;
  logic [DEV_W-1:0]  best_idx;
  logic              rsp_valid;
  logic [DEV_W-1:0]  out_dev;
  logic [TIME_W-1:0] out_time;
  logic [PRIO_W-1:0] out_prio;
  logic              in_range;
  logic              scan_last;
  logic              load_go;

  // configuration port
  assign pready = 1'b1;
  assign prdata = PDATA_W'(active_devices);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_devices <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0)) begin
      active_devices <= pwdata[ACT_W-1:0];
    end
  end

  always_comb begin
    if (active_devices == '0) begin
      eff_n = ACT_W'(1);
    end else if (active_devices > ACT_W'(MAX_DEVICES)) begin
      eff_n = ACT_W'(MAX_DEVICES);
    end else begin
      eff_n = active_devices;
    end
  end

  assign in_range  = {1'b0, req.device} < eff_n;
  assign scan_last = {1'b0, scan_cnt} == (eff_n - ACT_W'(1));
  assign load_go   = (state == S_LOAD) && (!rsp_valid || rsp.ready);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.next_device = out_dev;
  assign rsp.next_time   = out_time;
  assign rsp.next_func   = out_prio;

  assign ram_we    = (state == S_WRITE);
  assign ram_raddr = (state == S_SCAN) ? scan_cnt : chosen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chosen    <= '0;
      scan_cnt  <= '0;
      cmp.valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cmp.valid <= (state == S_SCAN);
      if (load_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            wr_dev <= req.device;
            case (req.req_type)
              REQ_ADD: begin
                wr_time <= req.event_time;
                wr_prio <= req.func_priority;
                state   <= in_range ? S_WRITE : S_READ;
              end
              REQ_REMOVE: begin
                wr_time <= SLOT_IDLE_TIME;
                wr_prio <= PRIO_NONE;
                state   <= in_range ? S_WRITE : S_READ;
              end
              REQ_FIND: begin
                scan_cnt <= '0;
                state    <= S_SCAN;
              end
              default: begin
                state <= S_READ;
              end
            endcase
          end
        end
        S_WRITE: begin
          state <= S_READ;
        end
        S_SCAN: begin
          cmp.first <= (scan_cnt == '0);
          cmp.idx   <= scan_cnt;
          scan_cnt  <= scan_cnt + DEV_W'(1);
          if (scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          chosen <= best_idx;
          state  <= S_READ;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load_go) begin
            out_dev  <= chosen;
            out_time <= rd_time;
            out_prio <= rd_prio;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  esms_slot_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (ram_we),
    .waddr   (wr_dev),
    .wtime   (wr_time),
    .wprio   (wr_prio),
    .raddr   (ram_raddr),
    .rd_time (rd_time),
    .rd_prio (rd_prio)
  );

  esms_min_unit u_min (
    .clk      (clk),
    .cmp      (cmp),
    .rd_time  (rd_time),
    .rd_prio  (rd_prio),
    .best_idx (best_idx)
  );

  a_commit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |=> ({1'b0, chosen} < eff_n))
    else $error("selection outside active slots");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN) |-> !ram_we)
    else $error("slot write during scan");

  a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp.valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("compare outside scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("request transfer left sequencer idle");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the event slot minimum select core. A directed table
// covers reset state, time and priority extremes, tie breaks, ignored devices,
// the spare request code and active counts out of range. Random traffic with
// random stalls on both channels follows, over several active counts. Every
// response is checked against pinned table values or an in-bench slot model.
// ----------------------------------------------------------------------------
module tb
  import esms_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0]   REQ_SPARE     = 2'd3;
  localparam logic [PADDR_W-1:0] REG_ACTIVE    = '0;
  localparam int                 QUIET_CYCLES  = 2 * (MAX_DEVICES + 4);
  localparam int                 HOLD_CYCLES   = 300;
  localparam int                 PHASE_ITEMS   = 220;
  localparam int                 NUM_PHASES    = 8;
  localparam int                 MAX_REPORTS   = 10;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [DEV_W-1:0]  device;
    logic [TIME_W-1:0] when;
    logic [PRIO_W-1:0] prio;
  } sched_req_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [TIME_W-1:0] when;
    logic [PRIO_W-1:0] prio;
  } slot_view_t;

  typedef struct packed {
    bit                cfg;
    logic [ACT_W-1:0]  act;
    logic [REQ_W-1:0]  kind;
    logic [DEV_W-1:0]  device;
    logic [TIME_W-1:0] when;
    logic [PRIO_W-1:0] prio;
    bit                pinned;
    logic [DEV_W-1:0]  x_dev;
    logic [TIME_W-1:0] x_when;
    logic [PRIO_W-1:0] x_prio;
  } step_row_t;

  localparam step_row_t DIRECTED [27] = '{
    '{0, 0, REQ_FIND,   0,  0,                     0,  1, 0,  SLOT_IDLE_TIME, PRIO_NONE},
    '{0, 0, REQ_ADD,    15, 0,                     15, 1, 0,  SLOT_IDLE_TIME, PRIO_NONE},
    '{0, 0, REQ_ADD,    0,  SLOT_IDLE_TIME,        15, 1, 0,  SLOT_IDLE_TIME, 15},
    '{0, 0, REQ_FIND,   0,  0,                     0,  1, 15, 0,              15},
    '{0, 0, REQ_ADD,    3,  0,                     15, 1, 15, 0,              15},
    '{0, 0, REQ_FIND,   9,  64'h1234,              7,  1, 3,  0,              15},
    '{0, 0, REQ_ADD,    7,  0,                     0,  0, 0,  0,              0},
    '{0, 0, REQ_REMOVE, 3,  0,                     0,  1, 3,  SLOT_IDLE_TIME, PRIO_NONE},
    '{0, 0, REQ_FIND,   0,  0,                     0,  1, 15, 0,              15},
    '{0, 0, REQ_SPARE,  15, SLOT_IDLE_TIME,        15, 1, 15, 0,              15},
    '{0, 0, REQ_ADD,    5,  64'h8000_0000_0000_0000, 8, 0, 0,  0,              0},
    '{1, 4, REQ_FIND,   0,  0,                     0,  0, 0,  0,              0},
    '{0, 0, REQ_ADD,    0,  5,                     1,  1, 15, 0,              15},
    '{0, 0, REQ_ADD,    15, 1,                     1,  1, 15, 0,              15},
    '{0, 0, REQ_FIND,   0,  0,                     0,  1, 0,  5,              1},
    '{0, 0, REQ_REMOVE, 9,  0,                     0,  0, 0,  0,              0},
    '{1, 1, REQ_FIND,   0,  0,                     0,  0, 0,  0,              0},
    '{0, 0, REQ_ADD,    1,  0,                     9,  0, 0,  0,              0},
    '{0, 0, REQ_FIND,   0,  0,                     0,  1, 0,  5,              1},
    '{1, 0, REQ_FIND,   0,  0,                     0,  0, 0,  0,              0},
    '{0, 0, REQ_ADD,    0,  2,                     2,  0, 0,  0,              0},
    '{0, 0, REQ_FIND,   0,  0,                     0,  0, 0,  0,              0},
    '{1, 31, REQ_FIND,  0,  0,                     0,  0, 0,  0,              0},
    '{0, 0, REQ_FIND,   0,  0,                     0,  1, 15, 0,              15},
    '{1, 16, REQ_FIND,  0,  0,                     0,  0, 0,  0,              0},
    '{0, 0, REQ_REMOVE, 15, 0,                     0,  1, 15, SLOT_IDLE_TIME, PRIO_NONE},
    '{0, 0, REQ_FIND,   0,  0,                     0,  0, 0,  0,              0}
  };

  localparam logic [ACT_W-1:0] PHASE_ACTIVE [NUM_PHASES] = '{16, 2, 16, 9, 1, 31, 16, 6};

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  esms_req_if req_ch ();
  esms_rsp_if rsp_ch ();

  event_slot_min_select_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // model of the slot store
  logic [TIME_W-1:0] slot_time_m [MAX_DEVICES];
  logic [PRIO_W-1:0] slot_prio_m [MAX_DEVICES];
  logic [DEV_W-1:0]  chosen_m;
  logic [ACT_W-1:0]  active_m;

  slot_view_t expected_picks [$];
  int unsigned mismatches;
  bit          hold_wanted;
  bit          calm;

  function automatic int unsigned live_slots();
    if (active_m == 0) return 1;
    if (active_m > MAX_DEVICES) return MAX_DEVICES;
    return active_m;
  endfunction

  function automatic slot_view_t schedule_step(input sched_req_t r);
    int unsigned live;
    logic [DEV_W-1:0] best;
    slot_view_t view;
    live = live_slots();
    case (r.kind)
      REQ_ADD: begin
        if (r.device < live) begin
          slot_time_m[r.device] = r.when;
          slot_prio_m[r.device] = r.prio;
        end
      end
      REQ_REMOVE: begin
        if (r.device < live) begin
          slot_time_m[r.device] = SLOT_IDLE_TIME;
          slot_prio_m[r.device] = PRIO_NONE;
        end
      end
      REQ_FIND: begin
        best = '0;
        for (int i = 1; i < live; i++) begin
          if (slot_time_m[i] < slot_time_m[best] ||
              (slot_time_m[i] == slot_time_m[best] && slot_prio_m[i] > slot_prio_m[best])) begin
            best = DEV_W'(i);
          end
        end
        chosen_m = best;
      end
      default: ;
    endcase
    view.dev  = chosen_m;
    view.when = slot_time_m[chosen_m];
    view.prio = slot_prio_m[chosen_m];
    return view;
  endfunction

  task automatic send_request(input sched_req_t r, input bit pinned, input slot_view_t want);
    slot_view_t model;
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= r.kind;
    req_ch.device        <= r.device;
    req_ch.event_time    <= r.when;
    req_ch.func_priority <= r.prio;
    do @(posedge clk); while (!req_ch.ready);
    model = schedule_step(r);
    expected_picks.push_back(pinned ? want : model);
  endtask

  task automatic quiesce();
    req_ch.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [ACT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ACTIVE;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    active_m = value;
  endtask

  // response sink with random stalls and one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    slot_view_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transfer: dev %0d time %h func %0d",
                   rsp_ch.next_device, rsp_ch.next_time, rsp_ch.next_func);
      end else begin
        want = expected_picks.pop_front();
        if (rsp_ch.next_device !== want.dev || rsp_ch.next_time !== want.when ||
            rsp_ch.next_func !== want.prio) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected dev %0d time %h func %0d, got dev %0d time %h func %0d",
                     want.dev, want.when, want.prio,
                     rsp_ch.next_device, rsp_ch.next_time, rsp_ch.next_func);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    sched_req_t  r;
    slot_view_t  want;
    int unsigned live;
    int unsigned roll;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_ADD;
    req_ch.device        <= '0;
    req_ch.event_time    <= '0;
    req_ch.func_priority <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    mismatches  = 0;
    hold_wanted = 1'b0;
    calm        = 1'b0;
    chosen_m    = '0;
    active_m    = ACTIVE_RESET;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      slot_time_m[i] = SLOT_IDLE_TIME;
      slot_prio_m[i] = PRIO_NONE;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg) begin
        quiesce();
        write_active(DIRECTED[i].act);
      end else begin
        r    = '{DIRECTED[i].kind, DIRECTED[i].device, DIRECTED[i].when, DIRECTED[i].prio};
        want = '{DIRECTED[i].x_dev, DIRECTED[i].x_when, DIRECTED[i].x_prio};
        send_request(r, DIRECTED[i].pinned, want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      write_active(PHASE_ACTIVE[ph]);
      calm = (ph == 3);
      if (ph == 0) hold_wanted = 1'b1;
      live = live_slots();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 45)      r.kind = REQ_ADD;
        else if (roll < 60) r.kind = REQ_REMOVE;
        else if (roll < 95) r.kind = REQ_FIND;
        else                r.kind = REQ_SPARE;
        if ($urandom_range(9) == 0) r.device = DEV_W'($urandom_range(MAX_DEVICES - 1));
        else                        r.device = DEV_W'($urandom_range(live - 1));
        case ($urandom_range(3))
          0: r.when = {$urandom, $urandom};
          1: r.when = TIME_W'($urandom_range(7));
          2: r.when = SLOT_IDLE_TIME - TIME_W'($urandom_range(3));
          default: r.when = $urandom_range(1) ? '0 : {$urandom, $urandom} >> $urandom_range(63);
        endcase
        r.prio = PRIO_W'($urandom_range(NUM_FUNCS - 1));
        send_request(r, 1'b0, '0);
      end
    end
    calm = 1'b0;

    quiesce();
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/esms_pkg.sv
sv/esms_req_if.sv
sv/esms_rsp_if.sv
sv/esms_slot_ram.sv
sv/esms_min_unit.sv
sv/event_slot_min_select_core.sv
sim/tb.sv
